>>> hdl/pcvu_pkg.sv
// ----------------------------------------------------------------------------
// PML corner velocity update package
// Shared types, register indexes and default sizes for the corner update block.
// ----------------------------------------------------------------------------
package pcvu_pkg;

    localparam int PML_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH   = 4;
    localparam int X_W           = 64;

    localparam logic [2:0] REG_TIME_STEP      = 3'd0;
    localparam logic [2:0] REG_STEP_OVER_CELL = 3'd1;
    localparam logic [2:0] REG_BUOYANCY       = 3'd2;
    localparam logic [2:0] REG_SIGN_I         = 3'd3;
    localparam logic [2:0] REG_SIGN_J         = 3'd4;
    localparam logic [2:0] REG_Q_ENABLE       = 3'd5;
    localparam logic [2:0] REG_Q_FACTOR       = 3'd6;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_UPDATE = 1'b1
    } op_t;

    typedef struct packed {
        logic [31:0] time_step;
        logic [31:0] step_over_cell;
        logic [31:0] buoyancy;
        logic        sign_i;
        logic        sign_j;
        logic        q_enable;
        logic [16:0] q_factor;
    } cfg_t;

    typedef struct packed {
        op_t                op;
        logic [6:0]         table_index;
        logic [X_W-1:0]     x;
        logic               axis_j;
        logic signed [31:0] old_velocity;
        logic signed [33:0] stress_diff;
    } entry_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] keep;
        logic [31:0] drive;
    } div_status_t;

endpackage

>>> hdl/pcvu_item_if.sv
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel carrying one load or update item.
// ----------------------------------------------------------------------------
interface pcvu_item_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [6:0]         table_index;
    logic [30:0]        attenuation;
    logic               axis_j;
    logic signed [31:0] old_velocity;
    logic signed [31:0] stress_ahead_i;
    logic signed [31:0] stress_ahead_j;
    logic signed [31:0] stress_behind_i;
    logic signed [31:0] stress_behind_j;

    modport source (
        output valid, action, table_index, attenuation, axis_j, old_velocity,
               stress_ahead_i, stress_ahead_j, stress_behind_i, stress_behind_j,
        input  ready
    );
    modport sink (
        input  valid, action, table_index, attenuation, axis_j, old_velocity,
               stress_ahead_i, stress_ahead_j, stress_behind_i, stress_behind_j,
        output ready
    );
endinterface

>>> hdl/pcvu_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one updated velocity and its saturation flag.
// ----------------------------------------------------------------------------
interface pcvu_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_velocity;
    logic               saturated;

    modport source (output valid, new_velocity, saturated, input ready);
    modport sink (input valid, new_velocity, saturated, output ready);
endinterface

>>> hdl/pcvu_setup_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface pcvu_setup_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/pcvu_queue.sv
// ----------------------------------------------------------------------------
// Work queue
// Short first-in first-out buffer between the front and back parts.
// ----------------------------------------------------------------------------
module pcvu_queue
    import pcvu_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    output logic   full,
    input  logic   pop,
    output entry_t pop_data,
    output logic   empty
);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    entry_t             store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [PTR_W:0]     count_reg, count_next;

    assign full     = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = store_reg[head_reg];

    always_comb
    begin
        head_next  = pop ? head_reg + 1'b1 : head_reg;
        tail_next  = push ? tail_reg + 1'b1 : tail_reg;
        count_next = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[tail_reg] <= push_data;
        end
    end
endmodule

>>> hdl/pcvu_front.sv
// ----------------------------------------------------------------------------
// Front part
// Accepts items, drops loads beyond the table, forms the damping product and
// the stress difference, and pushes work into the queue.
// ----------------------------------------------------------------------------
module pcvu_front
    import pcvu_pkg::*;
#(
    parameter int PML_WIDTH = PML_WIDTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    pcvu_item_if.sink item,
    input  cfg_t      cfg,
    input  logic      full,
    output logic      push,
    output entry_t    push_data
);
    localparam int DEPTH = 2 * PML_WIDTH + 1;

    logic           accept;
    logic           drop;
    logic [63:0]    damp_prod;

    assign item.ready = !full;
    assign accept     = item.valid && item.ready;
    assign drop       = (item.action == OP_LOAD) && (32'(item.table_index) >= DEPTH);
    assign push       = accept && !drop;
    assign damp_prod  = 64'(cfg.time_step) * 64'(item.attenuation);

    always_comb
    begin
        push_data.op           = op_t'(item.action);
        push_data.table_index  = item.table_index;
        push_data.x            = X_W'(damp_prod >> FRAC_BITS);
        push_data.axis_j       = item.axis_j;
        push_data.old_velocity = item.old_velocity;
        push_data.stress_diff  = 34'(item.stress_ahead_i) + 34'(item.stress_ahead_j)
                               - 34'(item.stress_behind_i) - 34'(item.stress_behind_j);
    end
endmodule

>>> hdl/pcvu_divider.sv
// ----------------------------------------------------------------------------
// Coefficient divider
// Radix-2 restoring divider that forms both damping coefficients, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcvu_divider
    import pcvu_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [X_W-1:0] divisor,
    output div_status_t    status
);
    logic           busy_reg;
    logic           done_reg;
    logic [4:0]     cnt_reg;
    logic [63:0]    d_reg;
    logic [63:0]    rem_k_reg, rem_d_reg;
    logic [31:0]    sh_k_reg, sh_d_reg;
    logic [31:0]    q_k_reg, q_d_reg;
    logic [63:0]    num_k, num_d;
    logic [63:0]    trial_k, trial_d;
    logic           ge_k, ge_d;

    always_comb
    begin
        num_k   = 64'h8000_0000_0000_0000 + (divisor >> 1);
        num_d   = 64'h4000_0000_0000_0000 + (divisor >> 1);
        trial_k = {rem_k_reg[62:0], sh_k_reg[31]};
        trial_d = {rem_d_reg[62:0], sh_d_reg[31]};
        ge_k    = trial_k >= d_reg;
        ge_d    = trial_d >= d_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd31;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_reg     <= divisor;
            rem_k_reg <= {32'b0, num_k[63:32]};
            rem_d_reg <= {32'b0, num_d[63:32]};
            sh_k_reg  <= num_k[31:0];
            sh_d_reg  <= num_d[31:0];
            q_k_reg   <= '0;
            q_d_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_k_reg <= ge_k ? trial_k - d_reg : trial_k;
            rem_d_reg <= ge_d ? trial_d - d_reg : trial_d;
            sh_k_reg  <= {sh_k_reg[30:0], 1'b0};
            sh_d_reg  <= {sh_d_reg[30:0], 1'b0};
            q_k_reg   <= {q_k_reg[30:0], ge_k};
            q_d_reg   <= {q_d_reg[30:0], ge_d};
        end
    end

    always_comb
    begin
        status.busy  = busy_reg || done_reg;
        status.done  = done_reg;
        status.keep  = q_k_reg - 32'h4000_0000;
        status.drive = q_d_reg;
    end
endmodule

>>> hdl/pcvu_back.sv
// ----------------------------------------------------------------------------
// Back part
// Runs loads through the divider into the coefficient table and updates
// through an eight-stage arithmetic pipeline ending in the output register.
// ----------------------------------------------------------------------------
module pcvu_back
    import pcvu_pkg::*;
#(
    parameter int PML_WIDTH = PML_WIDTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  logic         empty,
    input  entry_t       head,
    output logic         pop,
    output logic         div_start,
    output logic [X_W-1:0] div_divisor,
    input  div_status_t  div_status,
    pcvu_result_if.source result
);
    localparam int DEPTH  = 2 * PML_WIDTH + 1;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LAST   = DEPTH - 1;
    localparam logic [64:0] G_HALF  = 65'(1) << (FRAC_BITS - 1);
    localparam logic [92:0] MG_HALF = 93'(1) << (FRAC_BITS - 1);

    function automatic logic [32:0] sat32(input logic signed [63:0] x);
        logic [32:0] res;
        if (x > 64'sd2147483647)
        begin
            res = {1'b1, 32'h7FFF_FFFF};
        end
        else if (x < -64'sd2147483648)
        begin
            res = {1'b1, 32'h8000_0000};
        end
        else
        begin
            res = {1'b0, x[31:0]};
        end
        return res;
    endfunction

    logic [31:0]        keep_mem  [DEPTH];
    logic [31:0]        drive_mem [DEPTH];
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr_reg;
    logic               en;

    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;

    logic [31:0]        keep_q_reg, drive_q_reg;
    logic               axis1_reg;
    logic signed [31:0] vel1_reg;
    logic signed [33:0] s1_reg;

    logic [33:0]        ms;
    logic [65:0]        msd_reg;
    logic signed [63:0] kv_reg;
    logic [63:0]        gp_reg;
    logic               neg2_reg;

    logic [64:0]        g_sum;
    logic [63:0]        kv_mag;
    logic [33:0]        kvr_mag;
    logic [35:0]        m_reg;
    logic [56:0]        g_reg;
    logic signed [34:0] kvr3_reg;
    logic               neg3_reg;

    logic [64:0]        pl_reg;
    logic [63:0]        ph_reg;
    logic signed [34:0] kvr4_reg;
    logic               neg4_reg;

    logic [92:0]        mg;
    logic [92:0]        rnd;
    logic               cap;
    logic [40:0]        t_reg;
    logic signed [34:0] kvr5_reg;
    logic               neg5_reg;

    logic signed [42:0] t_signed;
    logic signed [42:0] r_sum;
    logic [32:0]        sat6;
    logic signed [31:0] r6_reg;
    logic               flag6_reg;

    logic signed [49:0] prod7_reg;
    logic signed [31:0] r7_reg;
    logic               flag7_reg;

    logic [49:0]        p_mag;
    logic [33:0]        p_rnd;
    logic signed [34:0] p_signed;
    logic [32:0]        sat8;
    logic signed [31:0] vel8_reg;
    logic               flag8_reg;

    assign en          = !v8_reg || result.ready;
    assign pop         = en && !empty && !div_status.busy;
    assign div_start   = pop && (head.op == OP_LOAD);
    assign div_divisor = X_W'(64'h1_0000_0000) + head.x;
    assign rd_addr     = (32'(head.table_index) >= DEPTH) ? ADDR_W'(LAST)
                                                          : ADDR_W'(head.table_index);

    always_ff @(posedge clk)
    begin
        if (div_status.done)
        begin
            keep_mem[wr_addr_reg]  <= div_status.keep;
            drive_mem[wr_addr_reg] <= div_status.drive;
        end
        if (en)
        begin
            keep_q_reg  <= keep_mem[rd_addr];
            drive_q_reg <= drive_mem[rd_addr];
        end
        if (div_start)
        begin
            wr_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= pop && (head.op == OP_UPDATE);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_comb
    begin
        ms       = s1_reg[33] ? 34'(-s1_reg) : 34'(s1_reg);
        g_sum    = 65'(gp_reg) + G_HALF;
        kv_mag   = kv_reg[63] ? 64'(-kv_reg) : 64'(kv_reg);
        kvr_mag  = 34'((kv_mag + 64'h2000_0000) >> 30);
        mg       = (93'(ph_reg) << 29) + 93'(pl_reg);
        rnd      = (mg + MG_HALF) >> FRAC_BITS;
        cap      = (mg > (93'(1) << 62)) || (rnd > (93'(1) << 40));
        t_signed = neg5_reg ? -$signed({2'b00, t_reg}) : $signed({2'b00, t_reg});
        r_sum    = 43'(kvr5_reg) + t_signed;
        sat6     = sat32(64'(r_sum));
        p_mag    = prod7_reg[49] ? 50'(-prod7_reg) : 50'(prod7_reg);
        p_rnd    = 34'((p_mag + 50'h8000) >> 16);
        p_signed = prod7_reg[49] ? -$signed({1'b0, p_rnd}) : $signed({1'b0, p_rnd});
        sat8     = sat32(64'(p_signed));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            axis1_reg <= head.axis_j;
            vel1_reg  <= head.old_velocity;
            s1_reg    <= head.stress_diff;

            msd_reg  <= ms * drive_q_reg;
            kv_reg   <= $signed(keep_q_reg) * vel1_reg;
            gp_reg   <= cfg.step_over_cell * cfg.buoyancy;
            neg2_reg <= s1_reg[33] ^ (axis1_reg ? cfg.sign_j : cfg.sign_i);

            m_reg    <= 36'((msd_reg + 66'h2000_0000) >> 30);
            g_reg    <= 57'(g_sum >> FRAC_BITS);
            kvr3_reg <= kv_reg[63] ? -$signed({1'b0, kvr_mag}) : $signed({1'b0, kvr_mag});
            neg3_reg <= neg2_reg;

            pl_reg   <= m_reg * g_reg[28:0];
            ph_reg   <= m_reg * g_reg[56:29];
            kvr4_reg <= kvr3_reg;
            neg4_reg <= neg3_reg;

            t_reg    <= cap ? 41'h100_0000_0000 : rnd[40:0];
            kvr5_reg <= kvr4_reg;
            neg5_reg <= neg4_reg;

            r6_reg    <= sat6[31:0];
            flag6_reg <= sat6[32];

            prod7_reg <= r6_reg * $signed({1'b0, cfg.q_factor});
            r7_reg    <= r6_reg;
            flag7_reg <= flag6_reg;

            vel8_reg  <= cfg.q_enable ? sat8[31:0] : r7_reg;
            flag8_reg <= flag7_reg || (cfg.q_enable && sat8[32]);
        end
    end

    assign result.valid        = v8_reg;
    assign result.new_velocity = vel8_reg;
    assign result.saturated    = flag8_reg;
endmodule

>>> hdl/pml_corner_velocity_update.sv
// ----------------------------------------------------------------------------
// PML corner velocity update
// Split-field PML velocity update for 2D FDTD corner regions, Q16.16 fixed
// point with saturation.
// ----------------------------------------------------------------------------
// An update item passes through the queue and the eight-stage back pipeline;
// one update transfer per cycle is sustained while the result channel is
// ready and no load holds the back part. A load holds the back part until
// the 32-step coefficient divider finishes; later items wait in the 4-entry
// queue meanwhile. Reset clears all control state and restores register
// defaults; table entries are undefined until loaded.
module pml_corner_velocity_update
    import pcvu_pkg::*;
#(
    parameter int PML_WIDTH = PML_WIDTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    pcvu_item_if.sink     item,
    pcvu_result_if.source result,
    pcvu_setup_if.sink    setup
);
    cfg_t           cfg_reg;
    logic           q_push, q_full, q_pop, q_empty;
    entry_t         q_in, q_out;
    logic           div_start;
    logic [X_W-1:0] div_divisor;
    div_status_t    div_status;

    assign setup.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.time_step      <= 32'd0;
            cfg_reg.step_over_cell <= 32'd65536;
            cfg_reg.buoyancy       <= 32'd65536;
            cfg_reg.sign_i         <= 1'b0;
            cfg_reg.sign_j         <= 1'b0;
            cfg_reg.q_enable       <= 1'b0;
            cfg_reg.q_factor       <= 17'd65536;
        end
        else if (setup.valid && setup.ready)
        begin
            unique case (setup.index)
                REG_TIME_STEP:      cfg_reg.time_step      <= setup.data;
                REG_STEP_OVER_CELL: cfg_reg.step_over_cell <= setup.data;
                REG_BUOYANCY:       cfg_reg.buoyancy       <= setup.data;
                REG_SIGN_I:         cfg_reg.sign_i         <= setup.data[0];
                REG_SIGN_J:         cfg_reg.sign_j         <= setup.data[0];
                REG_Q_ENABLE:       cfg_reg.q_enable       <= setup.data[0];
                REG_Q_FACTOR:       cfg_reg.q_factor       <= setup.data[16:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    pcvu_front #(
        .PML_WIDTH(PML_WIDTH),
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .item      (item),
        .cfg       (cfg_reg),
        .full      (q_full),
        .push      (q_push),
        .push_data (q_in)
    );

    pcvu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    pcvu_divider u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .divisor (div_divisor),
        .status  (div_status)
    );

    pcvu_back #(
        .PML_WIDTH(PML_WIDTH),
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .empty       (q_empty),
        .head        (q_out),
        .pop         (q_pop),
        .div_start   (div_start),
        .div_divisor (div_divisor),
        .div_status  (div_status),
        .result      (result)
    );

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_pop_filled: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_status.busy)
        else $error("divider started while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (div_status.busy && !q_pop))
        else $error("back part did not hold for divider");
endmodule
